// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

	// Bus sequencer phases, one half-bit per tick
	typedef enum logic [4:0] {
		PH_IDLE        = 5'd0,
		PH_START_REL   = 5'd1,
		PH_START_RISE  = 5'd2,
		PH_START_CHECK = 5'd3,
		PH_START_HOLD  = 5'd4,
		PH_TX_LOW      = 5'd5,
		PH_TX_HIGH     = 5'd6,
		PH_ACK_LOW     = 5'd7,
		PH_ACK_HIGH    = 5'd8,
		PH_ACK_CHECK   = 5'd9,
		PH_RX_HIGH     = 5'd10,
		PH_RX_SAMPLE   = 5'd11,
		PH_MACK_HIGH   = 5'd12,
		PH_MACK_END    = 5'd13,
		PH_STOP_RISE   = 5'd14,
		PH_STOP_REL    = 5'd15,
		PH_STOP_CHECK  = 5'd16
	} phase_t;

	// Which byte of the transaction is on the wire
	typedef enum logic [1:0] {
		SG_ADDR_W = 2'd0,
		SG_REG    = 2'd1,
		SG_DATA   = 2'd2,
		SG_ADDR_R = 2'd3
	} stage_t;

	localparam logic [1:0] MODE_WRITE = 2'd0;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BUS_BUSY  = 3'd1;
	localparam logic [2:0] ST_ADDR_NACK = 3'd2;
	localparam logic [2:0] ST_REG_NACK  = 3'd3;
	localparam logic [2:0] ST_DATA_NACK = 3'd4;
	localparam logic [2:0] ST_STOP_FAIL = 3'd5;

	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam logic       RW_READ  = 1'b1;

	typedef struct packed {
		logic       tick;
		logic       start_request;
		logic [1:0] mode;
		logic [6:0] slave_address;
		logic [7:0] register_address;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       data_request;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       done_res;
		logic [2:0] status;
	} rsp_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_counter;
		logic [7:0] shift_register;
		logic [7:0] bytes_left;
		logic [6:0] saved_target;
		logic [7:0] saved_register;
		logic [1:0] saved_mode;
		logic [2:0] error_code;
		logic       scl_level;
		logic       sda_level;
		stage_t     stage;
	} seq_state_t;

endpackage

// ===== rtl/i2cm_cmd_if.sv =====
interface i2cm_cmd_if;
	import i2cm_pkg::*;

	logic valid;
	logic ready;
	cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2cm_rsp_if.sv =====
interface i2cm_rsp_if;
	import i2cm_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2cm_seq.sv =====
module i2cm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  i2cm_pkg::cmd_t  item,
	output i2cm_pkg::rsp_t  result
);
	import i2cm_pkg::*;

	seq_state_t state_q;
	seq_state_t nxt;
	logic [3:0] bc_inc;
	logic [7:0] bl_dec;

	function automatic seq_state_t send_byte(seq_state_t s, logic [7:0] b);
		seq_state_t r;
		r = s;
		r.scl_level = 1'b0;
		r.sda_level = b[7];
		r.shift_register = {b[6:0], 1'b0};
		r.bit_counter = 4'd0;
		r.phase = PH_TX_HIGH;
		return r;
	endfunction

	function automatic seq_state_t begin_stop(seq_state_t s);
		seq_state_t r;
		r = s;
		r.scl_level = 1'b0;
		r.sda_level = 1'b0;
		r.phase = PH_STOP_RISE;
		return r;
	endfunction

	// Keep the first error; release both lines
	function automatic seq_state_t finish(seq_state_t s, logic [2:0] code);
		seq_state_t r;
		r = s;
		if (r.error_code == ST_OK) begin
			r.error_code = code;
		end
		r.scl_level = 1'b1;
		r.sda_level = 1'b1;
		r.phase = PH_IDLE;
		return r;
	endfunction

	assign bc_inc = state_q.bit_counter + 4'd1;
	assign bl_dec = state_q.bytes_left - 8'd1;

	// Next state
	always_comb begin
		nxt = state_q;
		if (state_q.phase == PH_IDLE) begin
			if (item.start_request) begin
				nxt.saved_mode = item.mode;
				nxt.saved_target = item.slave_address;
				nxt.saved_register = item.register_address;
				nxt.bytes_left = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
				nxt.error_code = ST_OK;
				nxt.stage = SG_ADDR_W;
				nxt.phase = PH_START_CHECK;
			end
		end else if (item.tick) begin
			unique case (state_q.phase)
				PH_START_REL: begin
					nxt.sda_level = 1'b1;
					nxt.phase = PH_START_RISE;
				end
				PH_START_RISE: begin
					nxt.scl_level = 1'b1;
					nxt.phase = PH_START_CHECK;
				end
				PH_START_CHECK: begin
					if (!item.sda_in) begin
						nxt = finish(state_q, ST_BUS_BUSY);
					end else begin
						nxt.sda_level = 1'b0;
						nxt.phase = PH_START_HOLD;
					end
				end
				PH_START_HOLD: begin
					nxt = send_byte(state_q, {state_q.saved_target,
						(state_q.stage == SG_ADDR_R) ? RW_READ : 1'b0});
				end
				PH_TX_LOW: begin
					nxt.scl_level = 1'b0;
					nxt.sda_level = |(state_q.shift_register & MSB_MASK);
					nxt.shift_register = {state_q.shift_register[6:0], 1'b0};
					nxt.phase = PH_TX_HIGH;
				end
				PH_TX_HIGH: begin
					nxt.scl_level = 1'b1;
					nxt.bit_counter = bc_inc;
					nxt.phase = bc_inc[3] ? PH_ACK_LOW : PH_TX_LOW;
				end
				PH_ACK_LOW: begin
					nxt.scl_level = 1'b0;
					nxt.sda_level = 1'b1;
					nxt.phase = PH_ACK_HIGH;
				end
				PH_ACK_HIGH: begin
					nxt.scl_level = 1'b1;
					nxt.phase = PH_ACK_CHECK;
				end
				PH_ACK_CHECK: begin
					if (item.sda_in) begin
						// Nack: record which byte failed, then stop
						case (state_q.stage)
							SG_REG:  nxt.error_code = ST_REG_NACK;
							SG_DATA: nxt.error_code = ST_DATA_NACK;
							default: nxt.error_code = ST_ADDR_NACK;
						endcase
						nxt = begin_stop(nxt);
					end else begin
						case (state_q.stage)
							SG_ADDR_W: begin
								if (state_q.saved_mode[1]) begin
									nxt = begin_stop(state_q);
								end else begin
									nxt.stage = SG_REG;
									nxt = send_byte(nxt, state_q.saved_register);
								end
							end
							SG_REG: begin
								if (state_q.saved_mode == MODE_WRITE) begin
									nxt.stage = SG_DATA;
									nxt = send_byte(nxt, item.write_byte);
								end else begin
									nxt.stage = SG_ADDR_R;
									nxt.scl_level = 1'b0;
									nxt.phase = PH_START_REL;
								end
							end
							SG_DATA: begin
								nxt.bytes_left = bl_dec;
								if (bl_dec != 8'd0) begin
									nxt = send_byte(nxt, item.write_byte);
								end else begin
									nxt = begin_stop(nxt);
								end
							end
							default: begin
								nxt.scl_level = 1'b0;
								nxt.sda_level = 1'b1;
								nxt.bit_counter = 4'd0;
								nxt.shift_register = 8'd0;
								nxt.phase = PH_RX_HIGH;
							end
						endcase
					end
				end
				PH_RX_HIGH: begin
					nxt.scl_level = 1'b1;
					nxt.phase = PH_RX_SAMPLE;
				end
				PH_RX_SAMPLE: begin
					nxt.shift_register = {state_q.shift_register[6:0], item.sda_in};
					nxt.bit_counter = bc_inc;
					nxt.scl_level = 1'b0;
					if (bc_inc[3]) begin
						// Master ack on all but the last byte
						nxt.sda_level = (state_q.bytes_left > 8'd1) ? 1'b0 : 1'b1;
						nxt.phase = PH_MACK_HIGH;
					end else begin
						nxt.sda_level = 1'b1;
						nxt.phase = PH_RX_HIGH;
					end
				end
				PH_MACK_HIGH: begin
					nxt.scl_level = 1'b1;
					nxt.phase = PH_MACK_END;
				end
				PH_MACK_END: begin
					nxt.bytes_left = bl_dec;
					if (bl_dec != 8'd0) begin
						nxt.scl_level = 1'b0;
						nxt.sda_level = 1'b1;
						nxt.bit_counter = 4'd0;
						nxt.shift_register = 8'd0;
						nxt.phase = PH_RX_HIGH;
					end else begin
						nxt = begin_stop(nxt);
					end
				end
				PH_STOP_RISE: begin
					nxt.scl_level = 1'b1;
					nxt.phase = PH_STOP_REL;
				end
				PH_STOP_REL: begin
					if (item.sda_in) begin
						nxt = finish(state_q, ST_STOP_FAIL);
					end else begin
						nxt.sda_level = 1'b1;
						nxt.phase = PH_STOP_CHECK;
					end
				end
				PH_STOP_CHECK: begin
					nxt = finish(state_q, item.sda_in ? ST_OK : ST_STOP_FAIL);
				end
				default: begin
					nxt = finish(state_q, ST_OK);
				end
			endcase
		end
	end

	// Outputs
	always_comb begin
		result = '0;
		result.scl_out = nxt.scl_level;
		result.sda_out = nxt.sda_level;
		result.busy_res = (nxt.phase != PH_IDLE);
		if (state_q.phase != PH_IDLE && item.tick) begin
			// Only a finish returns the sequencer to idle
			if (nxt.phase == PH_IDLE) begin
				result.done_res = 1'b1;
				result.status = nxt.error_code;
			end
			if (state_q.phase == PH_ACK_CHECK && !item.sda_in) begin
				result.data_request =
					(state_q.stage == SG_REG && state_q.saved_mode == MODE_WRITE) ||
					(state_q.stage == SG_DATA && bl_dec != 8'd0);
			end
			if (state_q.phase == PH_RX_SAMPLE && bc_inc[3]) begin
				result.read_valid = 1'b1;
				result.read_byte = {state_q.shift_register[6:0], item.sda_in};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				phase: PH_IDLE, bit_counter: 4'd0, shift_register: 8'd0,
				bytes_left: 8'd0, saved_target: 7'd0, saved_register: 8'd0,
				saved_mode: 2'd0, error_code: ST_OK, scl_level: 1'b1,
				sda_level: 1'b1, stage: SG_ADDR_W};
		end else if (advance) begin
			state_q <= nxt;
		end
	end

endmodule

// ===== rtl/i2c_master_register_access_unit.sv =====
// I2C master for burst register write, burst register read and address probe.
// cmd channel: one request per clock-domain step; each request carries the tick
// flag, the start fields, the next write byte and the sampled SDA level.
// rsp channel: exactly one response per request, in order, with the SCL/SDA
// drive after that step, busy/done/status, data_request and read_byte/valid.
// Response path: at the edge that accepts a request, the sequencer state register
// takes its next state and the combinational response is captured in the response
// register, or in the skid register while the response register still waits.
// Throughput: one request per cycle, limited only by the rsp side.
// A two-entry output stage (response register plus skid register) sits
// between the sides: cmd.ready stays high while the response register waits,
// and drops only when both entries hold untaken responses.
// Reset (arst_n low): sequencer idle, both lines released, stage empty.
// The line drive on SCL/SDA is only what the last taken response shows; a
// stalled receiver therefore freezes the bus once both output entries are full.
module i2c_master_register_access_unit (
	input logic       clk,
	input logic       arst_n,
	i2cm_cmd_if.sink  cmd,
	i2cm_rsp_if.source rsp
);
	import i2cm_pkg::*;

	rsp_t result;
	rsp_t out_q;
	rsp_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic push;
	logic pop;

	// Hold off requests only when both output entries are full
	assign cmd.ready = !skid_valid_q;
	assign push = cmd.valid && cmd.ready;
	assign pop = out_valid_q && rsp.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	// Advance the sequencer once per accepted request
	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(push),
		.item   (cmd.payload),
		.result (result)
	);

	// Output entry and skid entry valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payloads: refill from skid first, else from the new response
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= result;
			end
		end else if (push) begin
			skid_q <= result;
		end
	end

endmodule

// ===== rtl/i2cm_checker.sv =====
module i2cm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input i2cm_pkg::rsp_t rsp_payload
);
	import i2cm_pkg::*;

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled response changed");

	// With nothing pending on rsp the block must take requests
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> cmd_ready)
		else $error("request refused with empty output");

	// A finishing step leaves the bus idle and released
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.done_res |->
			!rsp_payload.busy_res && rsp_payload.scl_out && rsp_payload.sda_out)
		else $error("done while still busy");

	// Status is reported only on the finishing step
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.done_res)
		else $error("status without done");

	// Received bytes and write requests happen mid-transaction only
	a_mid_txn: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.read_valid || rsp_payload.data_request) |->
			rsp_payload.busy_res && !rsp_payload.done_res)
		else $error("data event outside a transaction");

endmodule

bind i2c_master_register_access_unit i2cm_checker u_i2cm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_payload(rsp.payload)
);

// ===== tb/tb_i2c_master_register_access_unit.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_register_access_unit;
	import i2cm_pkg::*;

	// Stop offering requests once this many bus steps have been taken
	localparam int unsigned TOTAL_STEPS = 1900;
	// Length of the one long receiver hold-off, and when it starts
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned HOLD_OFF_AFTER = 700;
	// Margin for stray responses after the last expected one is taken
	localparam int unsigned DRAIN_CYCLES = 8;
	// Slowest legal run is about 2.5 ms; allow several times that
	localparam int unsigned RUN_LIMIT_NS = 20_000_000;

	localparam logic [1:0] MODE_READ      = 2'd1;
	localparam logic [1:0] MODE_PROBE     = 2'd2;
	localparam logic [1:0] MODE_PROBE_ALT = 2'd3;

	// What the emulated target does wrong during one transaction
	typedef enum int {
		FLT_NONE,
		FLT_BUS_BUSY,
		FLT_ADDR_NACK,
		FLT_REG_NACK,
		FLT_DATA_NACK,
		FLT_RESTART_BUSY,
		FLT_READ_ADDR_NACK
	} fault_t;

	// How SDA behaves while the master sends STOP
	typedef enum int {
		STOP_CLEAN,
		STOP_STUCK_HIGH,
		STOP_STUCK_LOW
	} stop_t;

	typedef struct {
		logic [1:0] mode;
		logic [6:0] target;
		logic [7:0] regnum;
		logic [7:0] nbytes;
		fault_t     fault;
		logic [7:0] nack_at;   // bytes_left value on which the data ACK fails
		stop_t      stop_fault;
	} xfer_plan_t;

	// Bus sequencer model plus the queue of responses it predicts
	class i2c_step_scoreboard;
		seq_state_t  st;
		rsp_t        step_out;
		rsp_t        expected_steps[$];
		int unsigned steps_taken;
		int unsigned errors;

		function new();
			st = '0;
			st.phase = PH_IDLE;
			st.stage = SG_ADDR_W;
			st.scl_level = 1'b1;
			st.sda_level = 1'b1;
			steps_taken = 0;
			errors = 0;
		endfunction

		// Drop SCL and put the first bit of a byte on SDA
		function void load_byte(logic [7:0] b);
			st.scl_level = 1'b0;
			st.sda_level = (b & MSB_MASK) != 8'd0;
			st.shift_register = b << 1;
			st.bit_counter = 4'd0;
			st.phase = PH_TX_HIGH;
		endfunction

		function void open_stop();
			st.scl_level = 1'b0;
			st.sda_level = 1'b0;
			st.phase = PH_STOP_RISE;
		endfunction

		// Keep the first error seen; release both lines
		function void end_transfer(logic [2:0] code);
			if (st.error_code == ST_OK)
				st.error_code = code;
			st.scl_level = 1'b1;
			st.sda_level = 1'b1;
			st.phase = PH_IDLE;
			step_out.done_res = 1'b1;
			step_out.status = st.error_code;
		endfunction

		function void ack_slot(bit acked, logic [7:0] next_data);
			if (!acked) begin
				st.error_code = (st.stage == SG_REG) ? ST_REG_NACK :
					(st.stage == SG_DATA) ? ST_DATA_NACK : ST_ADDR_NACK;
				open_stop();
				return;
			end
			case (st.stage)
				SG_ADDR_W: begin
					if (st.saved_mode[1]) begin
						open_stop();
					end else begin
						st.stage = SG_REG;
						load_byte(st.saved_register);
					end
				end
				SG_REG: begin
					if (st.saved_mode == MODE_WRITE) begin
						st.stage = SG_DATA;
						step_out.data_request = 1'b1;
						load_byte(next_data);
					end else begin
						// repeated START for the read phase
						st.stage = SG_ADDR_R;
						st.scl_level = 1'b0;
						st.phase = PH_START_REL;
					end
				end
				SG_DATA: begin
					st.bytes_left = st.bytes_left - 8'd1;
					if (st.bytes_left != 8'd0) begin
						step_out.data_request = 1'b1;
						load_byte(next_data);
					end else begin
						open_stop();
					end
				end
				default: begin
					st.scl_level = 1'b0;
					st.sda_level = 1'b1;
					st.bit_counter = 4'd0;
					st.shift_register = 8'd0;
					st.phase = PH_RX_HIGH;
				end
			endcase
		endfunction

		// Advance the model by one accepted request and queue its response
		function void note_request(cmd_t c);
			step_out = '0;
			steps_taken++;
			if (st.phase == PH_IDLE) begin
				if (c.start_request) begin
					st.saved_mode = c.mode;
					st.saved_target = c.slave_address;
					st.saved_register = c.register_address;
					st.bytes_left = (c.byte_count == 8'd0) ? 8'd1 : c.byte_count;
					st.error_code = ST_OK;
					st.stage = SG_ADDR_W;
					st.phase = PH_START_CHECK;
				end
			end else if (c.tick) begin
				case (st.phase)
					PH_START_REL: begin
						st.sda_level = 1'b1;
						st.phase = PH_START_RISE;
					end
					PH_START_RISE: begin
						st.scl_level = 1'b1;
						st.phase = PH_START_CHECK;
					end
					PH_START_CHECK: begin
						if (!c.sda_in) begin
							end_transfer(ST_BUS_BUSY);
						end else begin
							st.sda_level = 1'b0;
							st.phase = PH_START_HOLD;
						end
					end
					PH_START_HOLD:
						load_byte({st.saved_target,
							((st.stage == SG_ADDR_R) ? RW_READ : 1'b0)});
					PH_TX_LOW: begin
						st.scl_level = 1'b0;
						st.sda_level = (st.shift_register & MSB_MASK) != 8'd0;
						st.shift_register = st.shift_register << 1;
						st.phase = PH_TX_HIGH;
					end
					PH_TX_HIGH: begin
						st.scl_level = 1'b1;
						st.bit_counter = st.bit_counter + 4'd1;
						st.phase = (st.bit_counter >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
					end
					PH_ACK_LOW: begin
						st.scl_level = 1'b0;
						st.sda_level = 1'b1;
						st.phase = PH_ACK_HIGH;
					end
					PH_ACK_HIGH: begin
						st.scl_level = 1'b1;
						st.phase = PH_ACK_CHECK;
					end
					PH_ACK_CHECK:
						ack_slot(!c.sda_in, c.write_byte);
					PH_RX_HIGH: begin
						st.scl_level = 1'b1;
						st.phase = PH_RX_SAMPLE;
					end
					PH_RX_SAMPLE: begin
						st.shift_register = {st.shift_register[6:0], c.sda_in};
						st.bit_counter = st.bit_counter + 4'd1;
						st.scl_level = 1'b0;
						if (st.bit_counter >= 4'd8) begin
							step_out.read_valid = 1'b1;
							step_out.read_byte = st.shift_register;
							// ACK all but the last byte
							st.sda_level = !(st.bytes_left > 8'd1);
							st.phase = PH_MACK_HIGH;
						end else begin
							st.sda_level = 1'b1;
							st.phase = PH_RX_HIGH;
						end
					end
					PH_MACK_HIGH: begin
						st.scl_level = 1'b1;
						st.phase = PH_MACK_END;
					end
					PH_MACK_END: begin
						st.bytes_left = st.bytes_left - 8'd1;
						if (st.bytes_left != 8'd0) begin
							st.scl_level = 1'b0;
							st.sda_level = 1'b1;
							st.bit_counter = 4'd0;
							st.shift_register = 8'd0;
							st.phase = PH_RX_HIGH;
						end else begin
							open_stop();
						end
					end
					PH_STOP_RISE: begin
						st.scl_level = 1'b1;
						st.phase = PH_STOP_REL;
					end
					PH_STOP_REL: begin
						if (c.sda_in) begin
							end_transfer(ST_STOP_FAIL);
						end else begin
							st.sda_level = 1'b1;
							st.phase = PH_STOP_CHECK;
						end
					end
					PH_STOP_CHECK:
						end_transfer(c.sda_in ? ST_OK : ST_STOP_FAIL);
					default:
						end_transfer(ST_OK);
				endcase
			end
			step_out.scl_out = st.scl_level;
			step_out.sda_out = st.sda_level;
			step_out.busy_res = (st.phase != PH_IDLE);
			expected_steps.push_back(step_out);
		endfunction

		function void compare(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_steps.size() == 0) begin
				$error("response arrived with no request outstanding");
				errors++;
				return;
			end
			want = expected_steps.pop_front();
			compare("scl_out", 8'(want.scl_out), 8'(got.scl_out));
			compare("sda_out", 8'(want.sda_out), 8'(got.sda_out));
			compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			compare("data_request", 8'(want.data_request), 8'(got.data_request));
			compare("read_byte", want.read_byte, got.read_byte);
			compare("read_valid", 8'(want.read_valid), 8'(got.read_valid));
			compare("done_res", 8'(want.done_res), 8'(got.done_res));
			compare("status", 8'(want.status), 8'(got.status));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	i2cm_cmd_if cmd_ch();
	i2cm_rsp_if rsp_ch();

	i2c_master_register_access_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	i2c_step_scoreboard sb = new();

	xfer_plan_t directed_xfers[$];
	xfer_plan_t active;
	bit         active_directed;
	bit         requests_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold reset at the start of the run, then release it for good
	initial begin : reset_gen
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int unsigned idle_cycles();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic xfer_plan_t xfer(logic [1:0] mode, logic [6:0] target,
			logic [7:0] regnum, logic [7:0] nbytes, fault_t fault,
			logic [7:0] nack_at, stop_t stop_fault);
		xfer_plan_t p;
		p.mode = mode;
		p.target = target;
		p.regnum = regnum;
		p.nbytes = nbytes;
		p.fault = fault;
		p.nack_at = nack_at;
		p.stop_fault = stop_fault;
		return p;
	endfunction

	// Build the next bus step. While a transaction runs, SDA plays the target:
	// ACK, free bus and a clean STOP unless the plan injects a fault; read data
	// bits are random. Outside the sampled slots SDA is noise.
	function automatic cmd_t next_request();
		cmd_t        c;
		seq_state_t  s;
		int unsigned roll;
		int unsigned eff;
		bit          nack;
		s = sb.st;
		c.tick = active_directed ? 1'b1 : ($urandom_range(0, 99) < 85);
		c.start_request = 1'b0;
		c.mode = 2'($urandom);
		c.slave_address = 7'($urandom);
		c.register_address = 8'($urandom);
		c.byte_count = 8'($urandom);
		c.write_byte = active_directed ? (sb.steps_taken[0] ? 8'hFF : 8'h00) :
			8'($urandom);
		c.sda_in = 1'($urandom);
		if (s.phase == PH_IDLE) begin
			if (directed_xfers.size() != 0 || $urandom_range(0, 3) != 0) begin
				if (directed_xfers.size() != 0) begin
					active = directed_xfers.pop_front();
					active_directed = 1'b1;
				end else begin
					active_directed = 1'b0;
					roll = $urandom_range(0, 99);
					active.mode = (roll < 40) ? MODE_WRITE : (roll < 75) ? MODE_READ :
						(roll < 92) ? MODE_PROBE : MODE_PROBE_ALT;
					active.target = 7'($urandom);
					active.regnum = 8'($urandom);
					roll = $urandom_range(0, 99);
					if (active.mode[1])
						active.nbytes = 8'($urandom);
					else if (roll < 72)
						active.nbytes = 8'($urandom_range(1, 4));
					else if (roll < 84)
						active.nbytes = 8'd0;
					else if (roll < 97 || active.mode != MODE_WRITE)
						active.nbytes = 8'($urandom_range(5, 16));
					else
						active.nbytes = 8'($urandom_range(17, 255));
					eff = (active.nbytes == 8'd0) ? 32'd1 : 32'(active.nbytes);
					active.fault = ($urandom_range(0, 99) < 80) ? FLT_NONE :
						fault_t'($urandom_range(1, 6));
					active.nack_at = 8'($urandom_range(1, eff));
					// cut long writes short with a data NACK
					if (active.mode == MODE_WRITE && eff > 16) begin
						active.fault = FLT_DATA_NACK;
						active.nack_at = 8'(eff - $urandom_range(0, 3));
					end
					roll = $urandom_range(0, 99);
					active.stop_fault = (roll < 90) ? STOP_CLEAN :
						(roll < 95) ? STOP_STUCK_HIGH : STOP_STUCK_LOW;
				end
				c.start_request = 1'b1;
				c.mode = active.mode;
				c.slave_address = active.target;
				c.register_address = active.regnum;
				c.byte_count = active.nbytes;
			end
		end else begin
			// start requests while busy must be ignored
			if (!active_directed)
				c.start_request = ($urandom_range(0, 4) == 0);
			case (s.phase)
				PH_START_CHECK:
					c.sda_in = !((active.fault == FLT_BUS_BUSY && s.stage == SG_ADDR_W) ||
						(active.fault == FLT_RESTART_BUSY && s.stage == SG_ADDR_R));
				PH_ACK_CHECK: begin
					nack = (active.fault == FLT_ADDR_NACK && s.stage == SG_ADDR_W) ||
						(active.fault == FLT_REG_NACK && s.stage == SG_REG) ||
						(active.fault == FLT_DATA_NACK && s.stage == SG_DATA &&
							s.bytes_left == active.nack_at) ||
						(active.fault == FLT_READ_ADDR_NACK && s.stage == SG_ADDR_R);
					c.sda_in = nack;
				end
				PH_STOP_REL:
					c.sda_in = (active.stop_fault == STOP_STUCK_HIGH);
				PH_STOP_CHECK:
					c.sda_in = (active.stop_fault != STOP_STUCK_LOW);
				default: ;
			endcase
		end
		return c;
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic offer_request(input cmd_t req);
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= req;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sb.note_request(req);
	endtask

	task automatic pause_requests(input int unsigned cycles);
		cmd_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin : request_side
		int unsigned gap;
		int unsigned steady;
		steady = 0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;

		// Directed transactions: field extremes, every mode, every error path
		directed_xfers.push_back(xfer(MODE_PROBE, 7'h00, 8'h00, 8'd1,
			FLT_NONE, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_PROBE_ALT, 7'h7F, 8'hFF, 8'd0,
			FLT_NONE, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_WRITE, 7'h55, 8'hFF, 8'd0,
			FLT_NONE, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_WRITE, 7'h2A, 8'h00, 8'd2,
			FLT_NONE, 8'd0, STOP_STUCK_HIGH));
		directed_xfers.push_back(xfer(MODE_READ, 7'h7F, 8'h81, 8'd3,
			FLT_NONE, 8'd0, STOP_STUCK_LOW));
		directed_xfers.push_back(xfer(MODE_READ, 7'h01, 8'h10, 8'd255,
			FLT_BUS_BUSY, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_WRITE, 7'h40, 8'h7E, 8'd255,
			FLT_DATA_NACK, 8'd253, STOP_CLEAN));
		// NACK on the final data byte must still be reported
		directed_xfers.push_back(xfer(MODE_WRITE, 7'h12, 8'h34, 8'd2,
			FLT_DATA_NACK, 8'd1, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_WRITE, 7'h3C, 8'h5A, 8'd1,
			FLT_ADDR_NACK, 8'd0, STOP_STUCK_HIGH));
		directed_xfers.push_back(xfer(MODE_WRITE, 7'h4B, 8'hC3, 8'd1,
			FLT_REG_NACK, 8'd0, STOP_STUCK_LOW));
		directed_xfers.push_back(xfer(MODE_READ, 7'h66, 8'hA5, 8'd2,
			FLT_REG_NACK, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_READ, 7'h19, 8'h01, 8'd1,
			FLT_RESTART_BUSY, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_READ, 7'h08, 8'h80, 8'd1,
			FLT_READ_ADDR_NACK, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_PROBE, 7'h50, 8'h00, 8'd0,
			FLT_ADDR_NACK, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_READ, 7'h5D, 8'h42, 8'd4,
			FLT_NONE, 8'd0, STOP_CLEAN));
		directed_xfers.push_back(xfer(MODE_WRITE, 7'h23, 8'h99, 8'd3,
			FLT_NONE, 8'd0, STOP_CLEAN));
		active = directed_xfers[0];
		active_directed = 1'b1;

		wait (arst_n === 1'b1);
		@(posedge clk);
		while (sb.steps_taken < TOTAL_STEPS) begin
			offer_request(next_request());
			// alternate stretches with no gaps and stretches with random gaps
			if (steady > 0) begin
				steady--;
			end else begin
				gap = idle_cycles();
				if ($urandom_range(0, 29) == 0)
					steady = $urandom_range(40, 160);
				if (gap > 0)
					pause_requests(gap);
			end
		end
		cmd_ch.valid <= 1'b0;
		requests_done = 1'b1;
	end

	// Take responses with random stalls; once, hold off long enough to back
	// the block up into its request side
	initial begin : response_side
		int unsigned stall;
		int unsigned steady;
		bit          held_off;
		stall = 0;
		steady = 0;
		held_off = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				sb.check_response(rsp_ch.payload);
			if (!held_off && sb.steps_taken >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				stall = HOLD_OFF_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (steady > 0) begin
					steady--;
				end else begin
					stall = idle_cycles();
					if ($urandom_range(0, 29) == 0)
						steady = $urandom_range(40, 160);
				end
			end
		end
	end

	// Drain outstanding responses, allow for stragglers, then report
	initial begin : end_of_run
		while (!requests_done) @(posedge clk);
		while (sb.expected_steps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_steps.size() == 0) begin
			$display("tb_i2c_master_register_access_unit: done, clean");
		end else begin
			$display("tb_i2c_master_register_access_unit: done, errors");
		end
		$finish;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("tb_i2c_master_register_access_unit: done, errors");
		$finish;
	end

endmodule
